FILE: design/aprq_pkg.sv
// ============================================================================
// aprq_pkg: shared types and constants
// Types, constants and state codes of the retry queue unit.
// ============================================================================
package aprq_pkg;

    localparam int unsigned QUEUE_DEPTH = 1024;
    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam int unsigned ENTRY_W = 32 + 16 + 16 + 32;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PENDING = 1'd1;
    localparam logic [15:0] RETRY_WINDOW_RESET = 16'd300;
    localparam logic [9:0] MAX_PENDING_RESET = 10'd1000;

    typedef enum logic [1:0] {
        REQ_ADD = 2'd0,
        REQ_ACK = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [15:0] msg_id;
        logic [15:0] payload_handle;
        logic [31:0] seq_key;
        logic [31:0] wall_time;
        logic [31:0] now_ticks;
        logic link_up;
    } in_item_t;

    typedef struct packed {
        logic [31:0] assigned_seq;
        logic send_valid;
        logic [15:0] send_msg_id;
        logic [15:0] send_handle;
        logic ack_found;
        logic [10:0] dropped_overflow;
        logic [10:0] dropped_expired;
        logic [10:0] queue_level;
    } out_item_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] kind;
        logic [15:0] handle;
        logic [31:0] deadline;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_ACK_RD,
        ST_ACK_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_OVF,
        ST_EXP_RD,
        ST_EXP_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic add;
        logic rd_search;
        logic search_next;
        logic ack_hit;
        logic rd_shift;
        logic wr_shift;
        logic shift_next;
        logic drop_head_ovf;
        logic rd_head;
        logic drop_head_exp;
        logic send;
        logic finish;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic link;
        logic full;
        logic over_limit;
        logic search_end;
        logic key_match;
        logic shift_end;
        logic empty;
        logic head_expired;
    } status_t;

endpackage

FILE: design/aprq_stream_if.sv
// ============================================================================
// aprq_stream_if: valid/ready channel
// Carries one beat of a payload type between a source and a sink.
// ============================================================================
interface aprq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: design/ack_pending_retry_queue_unit.sv
// ============================================================================
// ack_pending_retry_queue_unit: retransmission queue with deadlines
// Ordered store of requests awaiting acknowledgment, with resend offers.
// ============================================================================
// An add or tick runs the overflow check, dropping head entries over the limit,
// then, with the link up, the expiry check on the head; an acknowledge searches
// the entries, then shifts the later ones down on a hit.
// One beat is handled at a time; a result that waits at the output holds off
// the next beat.
// Reset: occupancy and last sequence clear at once; no clearing pass.
module ack_pending_retry_queue_unit (
    input logic clk,
    input logic rst_n,
    aprq_stream_if.sink in_ch,
    aprq_stream_if.source out_ch,
    input logic cfg_we,
    input logic [aprq_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [aprq_pkg::CFG_W-1:0] cfg_data
);
    aprq_pkg::cmd_t cmd;
    aprq_pkg::status_t sts;
    aprq_pkg::out_item_t result;
    logic [15:0] retry_window_reg;
    logic [9:0] max_pending_reg;
    logic out_valid_reg;
    aprq_pkg::out_item_t out_reg;

    // Configuration registers; the user must write them only while idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_window_reg <= aprq_pkg::RETRY_WINDOW_RESET;
            max_pending_reg <= aprq_pkg::MAX_PENDING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aprq_pkg::CFG_RETRY_WINDOW: retry_window_reg <= cfg_data;
                aprq_pkg::CFG_MAX_PENDING: max_pending_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    aprq_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .out_busy(out_valid_reg && !out_ch.ready),
        .sts(sts),
        .cmd(cmd)
    );

    aprq_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .item(in_ch.payload),
        .retry_window(retry_window_reg),
        .max_pending(max_pending_reg),
        .cmd(cmd),
        .sts(sts),
        .result(result)
    );

    // Output register: a finished result waits here until the receiver takes
    // it, and no new beat is taken while it waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ch.ready))
        else $error("result overwrote a waiting beat");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !out_valid_reg || out_ch.ready)
        else $error("beat taken while output stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished result not presented");
endmodule

FILE: design/aprq_ram.sv
// ============================================================================
// aprq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module aprq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input logic clk,
    input logic we,
    input logic [$clog2(DEPTH)-1:0] waddr,
    input logic [WIDTH-1:0] wdata,
    input logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/aprq_ctrl.sv
// ============================================================================
// aprq_ctrl: sequencing controller
// Steps each beat through add, search, shift, overflow and expiry phases.
// ============================================================================
module aprq_ctrl (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    output logic in_ready,
    input logic out_busy,
    input aprq_pkg::status_t sts,
    output aprq_pkg::cmd_t cmd
);
    aprq_pkg::state_t state_reg, state_next;
    logic service_reg, service_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aprq_pkg::ST_IDLE;
            service_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            service_reg <= service_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        service_next = service_reg;
        case (state_reg)
            aprq_pkg::ST_IDLE:
            begin
                if (in_valid && !out_busy)
                begin
                    state_next = aprq_pkg::ST_ADD;
                end
            end
            aprq_pkg::ST_ADD:
            begin
                case (sts.req)
                    aprq_pkg::REQ_ADD:
                    begin
                        service_next = 1'b1;
                        state_next = sts.full ? aprq_pkg::ST_SHIFT_RD : aprq_pkg::ST_OVF;
                    end
                    aprq_pkg::REQ_ACK:
                    begin
                        service_next = 1'b0;
                        state_next = aprq_pkg::ST_ACK_RD;
                    end
                    aprq_pkg::REQ_TICK: state_next = aprq_pkg::ST_OVF;
                    default: state_next = aprq_pkg::ST_DONE;
                endcase
            end
            aprq_pkg::ST_ACK_RD:
            begin
                state_next = sts.search_end ? aprq_pkg::ST_DONE : aprq_pkg::ST_ACK_CMP;
            end
            aprq_pkg::ST_ACK_CMP:
            begin
                state_next = sts.key_match ? aprq_pkg::ST_SHIFT_RD : aprq_pkg::ST_ACK_RD;
            end
            aprq_pkg::ST_SHIFT_RD:
            begin
                state_next = sts.shift_end ? (service_reg ? aprq_pkg::ST_OVF
                                                          : aprq_pkg::ST_DONE)
                                           : aprq_pkg::ST_SHIFT_WR;
            end
            aprq_pkg::ST_SHIFT_WR: state_next = aprq_pkg::ST_SHIFT_RD;
            aprq_pkg::ST_OVF:
            begin
                if (!sts.over_limit)
                begin
                    state_next = sts.link ? aprq_pkg::ST_EXP_RD : aprq_pkg::ST_DONE;
                end
            end
            aprq_pkg::ST_EXP_RD:
            begin
                state_next = sts.empty ? aprq_pkg::ST_DONE : aprq_pkg::ST_EXP_CMP;
            end
            aprq_pkg::ST_EXP_CMP:
            begin
                state_next = sts.head_expired ? aprq_pkg::ST_EXP_RD : aprq_pkg::ST_DONE;
            end
            aprq_pkg::ST_DONE:
            begin
                service_next = 1'b0;
                state_next = aprq_pkg::ST_IDLE;
            end
            default: state_next = aprq_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            aprq_pkg::ST_IDLE:
            begin
                in_ready = !out_busy;
                cmd.load = in_valid && !out_busy;
            end
            aprq_pkg::ST_ADD:
            begin
                cmd.add = (sts.req == aprq_pkg::REQ_ADD);
                cmd.rd_search = (sts.req == aprq_pkg::REQ_ACK);
            end
            aprq_pkg::ST_ACK_RD: cmd.rd_search = 1'b0;
            aprq_pkg::ST_ACK_CMP:
            begin
                cmd.ack_hit = sts.key_match;
                cmd.search_next = !sts.key_match;
            end
            aprq_pkg::ST_SHIFT_RD: cmd.rd_shift = !sts.shift_end;
            aprq_pkg::ST_SHIFT_WR: cmd.wr_shift = 1'b1;
            aprq_pkg::ST_OVF: cmd.drop_head_ovf = sts.over_limit;
            aprq_pkg::ST_EXP_RD: cmd.rd_head = 1'b1;
            aprq_pkg::ST_EXP_CMP:
            begin
                cmd.drop_head_exp = sts.head_expired;
                cmd.send = !sts.head_expired;
            end
            aprq_pkg::ST_DONE: cmd.finish = 1'b1;
            default: cmd = '0;
        endcase
    end
endmodule

FILE: design/aprq_datapath.sv
// ============================================================================
// aprq_datapath: queue storage and counters
// Circular entry store with head pointer, search and order-keeping removal.
// ============================================================================
module aprq_datapath (
    input logic clk,
    input logic rst_n,
    input aprq_pkg::in_item_t item,
    input logic [15:0] retry_window,
    input logic [9:0] max_pending,
    input aprq_pkg::cmd_t cmd,
    output aprq_pkg::status_t sts,
    output aprq_pkg::out_item_t result
);
    localparam int unsigned IW = aprq_pkg::IDX_W;
    localparam int unsigned CW = aprq_pkg::CNT_W;

    aprq_pkg::in_item_t item_reg;
    logic [31:0] last_seq_reg, last_seq_next;
    logic [IW-1:0] head_reg;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] pos_reg;
    logic [10:0] drop_ovf_reg, drop_exp_reg;
    logic [31:0] seq_out_reg;
    logic found_reg, send_reg;
    aprq_pkg::entry_t hold_reg;

    logic ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    aprq_pkg::entry_t ram_wdata, ram_rdata;
    logic [CW-1:0] last_pos;

    aprq_ram #(.WIDTH(aprq_pkg::ENTRY_W), .DEPTH(aprq_pkg::QUEUE_DEPTH)) u_store (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Positions are logical; physical address is head plus position.
    assign last_pos = occ_reg - CW'(1);

    always_comb
    begin
        if (last_seq_reg == 32'd0 || last_seq_reg < item_reg.wall_time)
        begin
            last_seq_next = item_reg.wall_time;
        end
        else
        begin
            last_seq_next = last_seq_reg + 32'd1;
        end
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = head_reg + IW'(pos_reg);
        ram_wdata = ram_rdata;
        ram_raddr = head_reg + IW'(pos_reg);
        if (cmd.add)
        begin
            ram_we = 1'b1;
            // A full store drops its head first, so the tail slot equals head.
            ram_waddr = head_reg + IW'(occ_reg);
            ram_wdata.seq = last_seq_next;
            ram_wdata.kind = item_reg.msg_id;
            ram_wdata.handle = item_reg.payload_handle;
            ram_wdata.deadline = item_reg.now_ticks + {16'd0, retry_window};
        end
        else if (cmd.wr_shift)
        begin
            ram_we = 1'b1;
            ram_waddr = head_reg + IW'(pos_reg) - IW'(1);
            ram_wdata = ram_rdata;
        end
        if (cmd.rd_head)
        begin
            ram_raddr = head_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg <= 32'd0;
            head_reg <= '0;
            occ_reg <= '0;
        end
        else
        begin
            if (cmd.add)
            begin
                last_seq_reg <= last_seq_next;
                if (occ_reg == CW'(aprq_pkg::QUEUE_DEPTH))
                begin
                    head_reg <= head_reg + IW'(1);
                end
                else
                begin
                    occ_reg <= occ_reg + CW'(1);
                end
            end
            if (cmd.ack_hit)
            begin
                occ_reg <= last_pos;
            end
            if (cmd.drop_head_ovf || cmd.drop_head_exp)
            begin
                head_reg <= head_reg + IW'(1);
                occ_reg <= last_pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            pos_reg <= '0;
            drop_ovf_reg <= '0;
            drop_exp_reg <= '0;
            seq_out_reg <= '0;
            found_reg <= 1'b0;
            send_reg <= 1'b0;
        end
        if (cmd.add)
        begin
            seq_out_reg <= last_seq_next;
            pos_reg <= CW'(1);
            if (occ_reg == CW'(aprq_pkg::QUEUE_DEPTH))
            begin
                drop_ovf_reg <= 11'd1;
            end
        end
        if (cmd.search_next)
        begin
            pos_reg <= pos_reg + CW'(1);
        end
        if (cmd.ack_hit)
        begin
            found_reg <= 1'b1;
            pos_reg <= pos_reg + CW'(1);
        end
        if (cmd.wr_shift)
        begin
            pos_reg <= pos_reg + CW'(1);
        end
        if (cmd.drop_head_ovf)
        begin
            drop_ovf_reg <= drop_ovf_reg + 11'd1;
        end
        if (cmd.drop_head_exp)
        begin
            drop_exp_reg <= drop_exp_reg + 11'd1;
        end
        if (cmd.send)
        begin
            send_reg <= 1'b1;
            hold_reg <= ram_rdata;
        end
    end

    // After an add the shift walk is never used, even when the store was full: it is
    // skipped because the head advance already dropped the oldest entry.
    always_comb
    begin
        sts.req = aprq_pkg::req_t'(item_reg.req_type);
        sts.link = item_reg.link_up;
        sts.full = 1'b0;
        sts.over_limit = occ_reg > {1'b0, max_pending};
        sts.search_end = pos_reg >= occ_reg;
        sts.key_match = ram_rdata.seq == item_reg.seq_key;
        // Shift copies entry pos to pos-1 for entries after the hit; occupancy shrinks at the hit.
        sts.shift_end = pos_reg > occ_reg;
        sts.empty = occ_reg == '0;
        sts.head_expired = ram_rdata.deadline < item_reg.now_ticks;
    end

    always_comb
    begin
        result.assigned_seq = seq_out_reg;
        result.send_valid = send_reg;
        result.send_msg_id = send_reg ? hold_reg.kind : 16'd0;
        result.send_handle = send_reg ? hold_reg.handle : 16'd0;
        result.ack_found = found_reg;
        result.dropped_overflow = drop_ovf_reg;
        result.dropped_expired = drop_exp_reg;
        result.queue_level = 11'(occ_reg);
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(aprq_pkg::QUEUE_DEPTH))
        else $error("occupancy beyond store depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_head_ovf |-> occ_reg != '0)
        else $error("overflow drop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add |=> occ_reg != '0)
        else $error("add left queue empty");
endmodule

FILE: verif/tb_ack_pending_retry_queue_unit.sv
// ============================================================================
// tb_ack_pending_retry_queue_unit: self-checking bench for the retry queue
// Drives adds, acknowledges and ticks through the valid/ready channels,
// predicts every result beat and compares it field by field.
// ============================================================================
module tb_ack_pending_retry_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [aprq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [aprq_pkg::CFG_W-1:0] cfg_data;

    aprq_stream_if #(.T(aprq_pkg::in_item_t)) in_ch ();
    aprq_stream_if #(.T(aprq_pkg::out_item_t)) out_ch ();

    ack_pending_retry_queue_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // The clock runs at 100 MHz.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor copy of the queue. Only entries below the pending count are
    // ever read, so the arrays need no initial contents.
    aprq_pkg::entry_t pend_q[$];
    logic [31:0] pred_last_seq;
    logic [15:0] pred_window;
    logic [9:0] pred_limit;

    aprq_pkg::out_item_t result_q[$];
    int unsigned mismatches;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned acks_hit;
    int unsigned sends_seen;
    int unsigned expiries;
    int unsigned overflows;
    int unsigned phase_cnt;
    bit hold_off;

    // Works out the result beat of one accepted item and updates the
    // predictor state, following the queue's rules exactly.
    function automatic aprq_pkg::out_item_t queue_outcome(input aprq_pkg::in_item_t it);
        aprq_pkg::out_item_t r;
        aprq_pkg::entry_t e;
        bit serv;
        r = '0;
        serv = 1'b0;
        case (aprq_pkg::req_t'(it.req_type))
            aprq_pkg::REQ_ADD:
            begin
                if (pred_last_seq == 32'd0 || pred_last_seq < it.wall_time)
                    pred_last_seq = it.wall_time;
                else
                    pred_last_seq = pred_last_seq + 32'd1;
                r.assigned_seq = pred_last_seq;
                if (pend_q.size() >= aprq_pkg::QUEUE_DEPTH)
                begin
                    void'(pend_q.pop_front());
                    r.dropped_overflow++;
                end
                e.seq = pred_last_seq;
                e.kind = it.msg_id;
                e.handle = it.payload_handle;
                e.deadline = it.now_ticks + {16'd0, pred_window};
                pend_q.insert(pend_q.size(), e);
                serv = 1'b1;
            end
            aprq_pkg::REQ_ACK:
            begin
                foreach (pend_q[i])
                begin
                    if (pend_q[i].seq == it.seq_key)
                    begin
                        pend_q.delete(i);
                        r.ack_found = 1'b1;
                        break;
                    end
                end
            end
            aprq_pkg::REQ_TICK: serv = 1'b1;
            default: ;
        endcase
        if (serv)
        begin
            while (pend_q.size() > pred_limit)
            begin
                void'(pend_q.pop_front());
                r.dropped_overflow++;
            end
            if (it.link_up)
            begin
                while (pend_q.size() > 0 && pend_q[0].deadline < it.now_ticks)
                begin
                    void'(pend_q.pop_front());
                    r.dropped_expired++;
                end
                if (pend_q.size() > 0)
                begin
                    r.send_valid = 1'b1;
                    r.send_msg_id = pend_q[0].kind;
                    r.send_handle = pend_q[0].handle;
                end
            end
        end
        r.queue_level = 11'(pend_q.size());
        return r;
    endfunction

    // Directed table. A row with check_fixed set also carries a result that
    // can be read straight off the rules; every row goes through the
    // predictor as well.
    typedef struct {
        aprq_pkg::in_item_t item;
        bit check_fixed;
        aprq_pkg::out_item_t fixed;
    } row_t;

    row_t rows[$];

    function automatic aprq_pkg::in_item_t mk(input aprq_pkg::req_t rq,
                                              input logic [15:0] kind,
                                              input logic [15:0] hdl,
                                              input logic [31:0] key,
                                              input logic [31:0] wall,
                                              input logic [31:0] now,
                                              input logic lk);
        aprq_pkg::in_item_t it;
        it.req_type = rq;
        it.msg_id = kind;
        it.payload_handle = hdl;
        it.seq_key = key;
        it.wall_time = wall;
        it.now_ticks = now;
        it.link_up = lk;
        return it;
    endfunction

    function automatic void add_row(input aprq_pkg::in_item_t it);
        row_t rw;
        rw.item = it;
        rw.check_fixed = 1'b0;
        rw.fixed = '0;
        rows.insert(rows.size(), rw);
    endfunction

    function automatic void add_fixed(input aprq_pkg::in_item_t it,
                                      input aprq_pkg::out_item_t ex);
        row_t rw;
        rw.item = it;
        rw.check_fixed = 1'b1;
        rw.fixed = ex;
        rows.insert(rows.size(), rw);
    endfunction

    function automatic void build_directed();
        aprq_pkg::out_item_t ex;
        // A tick on an empty queue right after reset changes nothing.
        ex = '0;
        add_fixed(mk(aprq_pkg::REQ_TICK, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b1), ex);
        // First add with a zero wall time: sequence comes out as zero, and the
        // link is down, so nothing is offered.
        ex = '0;
        ex.queue_level = 11'd1;
        add_fixed(mk(aprq_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b0), ex);
        // With last sequence still zero, the next add takes the wall time.
        ex = '0;
        ex.assigned_seq = 32'hFFFF_FFFF;
        ex.send_valid = 1'b1;
        ex.send_msg_id = 16'hFFFF;
        ex.send_handle = 16'hFFFF;
        ex.queue_level = 11'd2;
        add_fixed(mk(aprq_pkg::REQ_ADD, 16'h0, 16'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1),
                  ex);
        // Sequence wraps from all ones to zero when time has not advanced.
        add_row(mk(aprq_pkg::REQ_ADD, 16'h1234, 16'h5678, 32'h0, 32'h10, 32'h0, 1'b1));
        add_row(mk(aprq_pkg::REQ_ADD, 16'h1, 16'h2, 32'h0, 32'h10, 32'h0, 1'b1));
        // Acknowledge a missing key, then one that matches the middle, then the head.
        add_row(mk(aprq_pkg::REQ_ACK, 16'hAAAA, 16'h5555, 32'hDEAD_BEEF, 32'h0, 32'h0,
                   1'b1));
        add_row(mk(aprq_pkg::REQ_ACK, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 1'b0));
        add_row(mk(aprq_pkg::REQ_ACK, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b1));
        // The unused request type leaves the queue alone.
        ex = '0;
        ex.queue_level = 11'd2;
        add_fixed(mk(aprq_pkg::REQ_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 1'b1), ex);
        // Link down: no expiry even with the largest uptime.
        add_row(mk(aprq_pkg::REQ_TICK, 16'h0, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0));
        // Deadline wrap: an uptime near the top gives a small deadline.
        add_row(mk(aprq_pkg::REQ_ADD, 16'h77, 16'h88, 32'h0, 32'h20, 32'hFFFF_FF00, 1'b0));
        // Link up with the largest uptime expires everything.
        add_row(mk(aprq_pkg::REQ_TICK, 16'h0, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1));
        add_row(mk(aprq_pkg::REQ_ADD, 16'h9, 16'hA, 32'h0, 32'h5, 32'h100, 1'b1));
        add_row(mk(aprq_pkg::REQ_TICK, 16'h0, 16'h0, 32'h0, 32'h0, 32'h100, 1'b1));
        add_row(mk(aprq_pkg::REQ_ACK, 16'h0, 16'h0, 32'h21, 32'h0, 32'h0, 1'b1));
        add_row(mk(aprq_pkg::REQ_TICK, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    endfunction

    // Compare one result beat with the oldest expectation.
    task automatic check_beat(input aprq_pkg::out_item_t got);
        aprq_pkg::out_item_t want;
        if (result_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result beat with nothing expected: %h", $realtime, got);
            return;
        end
        want = result_q.pop_front();
        beats_out++;
        if (got.send_valid)
            sends_seen++;
        if (got.ack_found)
            acks_hit++;
        if (got.assigned_seq !== want.assigned_seq
            || got.send_valid !== want.send_valid
            || got.send_msg_id !== want.send_msg_id
            || got.send_handle !== want.send_handle
            || got.ack_found !== want.ack_found
            || got.dropped_overflow !== want.dropped_overflow
            || got.dropped_expired !== want.dropped_expired
            || got.queue_level !== want.queue_level)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: mismatch seq %h/%h snd %b/%b kind %h/%h hdl %h/%h",
                         $realtime, want.assigned_seq, got.assigned_seq,
                         want.send_valid, got.send_valid,
                         want.send_msg_id, got.send_msg_id,
                         want.send_handle, got.send_handle);
                $display("    ack %b/%b ovf %0d/%0d exp %0d/%0d lvl %0d/%0d",
                         want.ack_found, got.ack_found,
                         want.dropped_overflow, got.dropped_overflow,
                         want.dropped_expired, got.dropped_expired,
                         want.queue_level, got.queue_level);
            end
        end
    endtask

    // Result monitor. Outputs are sampled at the rising edge, and the beat
    // counts when both valid and ready were high there.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_beat(out_ch.payload);
    end

    // Receiver: stalls on a pattern of its own, with quiet stretches, and
    // holds off completely while the sender fills the queue.
    initial
    begin
        int unsigned pat;
        out_ch.ready = 1'b0;
        pat = 0;
        forever
        begin
            @(posedge clk);
            pat++;
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if ((pat / 200) % 3 == 2)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Sender side: drive one beat and wait for it to be taken. Bursts of
    // random length alternate with random gaps; valid stays high between
    // beats of one burst.
    int unsigned burst_left;

    task automatic send_item(input aprq_pkg::in_item_t it, input bit fixed_chk,
                             input aprq_pkg::out_item_t fixed_ex);
        aprq_pkg::out_item_t ex;
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        ex = queue_outcome(it);
        overflows += ex.dropped_overflow;
        expiries += ex.dropped_expired;
        if (fixed_chk && ex !== fixed_ex)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: directed row disagrees with predictor: %h vs %h",
                         $realtime, fixed_ex, ex);
        end
        result_q.insert(result_q.size(), ex);
        beats_in++;
    endtask

    // Configuration writes happen only with the block idle: the sender stops,
    // every expected beat has come back and a short settling pause has passed.
    task automatic write_reg(input logic [aprq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        in_ch.valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == aprq_pkg::CFG_RETRY_WINDOW)
            pred_window = val;
        else
            pred_limit = val[9:0];
    endtask

    // Random item: mostly adds and acknowledges of live sequence numbers,
    // with ticks and some noise, so the queue is kept busy and acks hit.
    logic [31:0] wall_clk;
    logic [31:0] up_clk;

    function automatic aprq_pkg::in_item_t rand_item(input int unsigned add_bias);
        aprq_pkg::in_item_t it;
        int unsigned pick;
        it.msg_id = 16'($urandom);
        it.payload_handle = 16'($urandom);
        it.seq_key = $urandom;
        it.link_up = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 3) == 0)
            wall_clk = wall_clk + $urandom_range(0, 3);
        up_clk = up_clk + $urandom_range(0, 40);
        it.wall_time = ($urandom_range(0, 50) == 0) ? $urandom : wall_clk;
        it.now_ticks = ($urandom_range(0, 50) == 0) ? $urandom : up_clk;
        pick = $urandom_range(0, 99);
        if (pick < add_bias)
            it.req_type = aprq_pkg::REQ_ADD;
        else if (pick < 85)
        begin
            it.req_type = aprq_pkg::REQ_ACK;
            if (pend_q.size() > 0 && $urandom_range(0, 3) != 0)
                it.seq_key = pend_q[$urandom_range(0, pend_q.size() - 1)].seq;
        end
        else if (pick < 97)
            it.req_type = aprq_pkg::REQ_TICK;
        else
            it.req_type = aprq_pkg::REQ_NONE;
        return it;
    endfunction

    // Long hold-off counted in its own process while the sender keeps on.
    initial
    begin
        hold_off = 1'b0;
        wait (phase_cnt == 2);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        row_t rw;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        rst_n = 1'b0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        acks_hit = 0;
        sends_seen = 0;
        expiries = 0;
        overflows = 0;
        phase_cnt = 0;
        burst_left = 0;
        pred_last_seq = '0;
        pred_window = aprq_pkg::RETRY_WINDOW_RESET;
        pred_limit = aprq_pkg::MAX_PENDING_RESET;
        wall_clk = 32'd1000;
        up_clk = 32'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings.
        build_directed();
        foreach (rows[i])
        begin
            rw = rows[i];
            send_item(rw.item, rw.check_fixed, rw.fixed);
        end

        // Phase 1: small limit and a zero window, so overflow and expiry
        // drops are frequent.
        write_reg(aprq_pkg::CFG_MAX_PENDING, 16'd4);
        write_reg(aprq_pkg::CFG_RETRY_WINDOW, 16'd0);
        phase_cnt = 1;
        repeat (400) send_item(rand_item(50), 1'b0, '0);

        // Phase 2: largest window and limit; the receiver holds off for a
        // while so the channels back up.
        write_reg(aprq_pkg::CFG_RETRY_WINDOW, 16'hFFFF);
        write_reg(aprq_pkg::CFG_MAX_PENDING, 16'd1023);
        phase_cnt = 2;
        repeat (600) send_item(rand_item(60), 1'b0, '0);

        // Phase 3: a zero limit drops everything on every service.
        write_reg(aprq_pkg::CFG_MAX_PENDING, 16'd0);
        write_reg(aprq_pkg::CFG_RETRY_WINDOW, 16'd1);
        phase_cnt = 3;
        repeat (150) send_item(rand_item(50), 1'b0, '0);

        // Phase 4: a middling limit and window with the usual mix.
        write_reg(aprq_pkg::CFG_MAX_PENDING, 16'd1);
        write_reg(aprq_pkg::CFG_MAX_PENDING, 16'd20);
        write_reg(aprq_pkg::CFG_RETRY_WINDOW, 16'd120);
        phase_cnt = 4;
        repeat (850) send_item(rand_item(45), 1'b0, '0);

        in_ch.valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d beats and checked %0d results across five register settings.",
                 beats_in, beats_out);
        $display("Seen %0d ack hits, %0d send offers, %0d overflow and %0d expiry drops.",
                 acks_hit, sends_seen, overflows, expiries);
        if (mismatches == 0 && result_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #100ms;
        $display("Timed out with %0d results still expected.", result_q.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
